FILE: design/smpa_pkg.sv
`default_nettype none

package smpa_pkg;

  localparam int COEF_W = 16;
  localparam int EXP_W  = 10;
  localparam int RES_W  = 17;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND_A = 3'd0,
    OP_APPEND_B = 3'd1,
    OP_ADD      = 3'd2,
    OP_SUB      = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    CMD_APPEND_A,
    CMD_APPEND_B,
    CMD_ADD,
    CMD_SUB,
    CMD_CLEAR
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_VALID   = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_EMPTY   = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0]         expo;
  } cmd_item_t;

endpackage

`default_nettype wire

FILE: design/smpa_in_if.sv
`default_nettype none

interface smpa_in_if;
  import smpa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [COEF_W-1:0] term_coefficient;
  logic [EXP_W-1:0]         term_exponent;

  modport source (output valid, output op, output term_coefficient, output term_exponent,
                  input ready);
  modport sink (input valid, input op, input term_coefficient, input term_exponent,
                output ready);
endinterface

`default_nettype wire

FILE: design/smpa_out_if.sv
`default_nettype none

interface smpa_out_if;
  import smpa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_coefficient;
  logic [EXP_W-1:0]        result_exponent;
  logic                    last_term;
  logic [STAT_W-1:0]       status;

  modport source (output valid, output result_coefficient, output result_exponent,
                  output last_term, output status, input ready);
  modport sink (input valid, input result_coefficient, input result_exponent,
                input last_term, input status, output ready);
endinterface

`default_nettype wire

FILE: design/smpa_front.sv
`default_nettype none

module smpa_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  smpa_in_if.sink                 in_ch,
  output logic                    q_valid,
  output smpa_pkg::cmd_item_t     q_item,
  input  wire logic               q_pop
);
  import smpa_pkg::*;

  cmd_item_t         queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              known;
  logic              push;
  cmd_t              cmd;

  always_comb begin
    known = 1'b1;
    cmd   = CMD_CLEAR;
    case (in_ch.op)
      OP_APPEND_A: cmd = CMD_APPEND_A;
      OP_APPEND_B: cmd = CMD_APPEND_B;
      OP_ADD:      cmd = CMD_ADD;
      OP_SUB:      cmd = CMD_SUB;
      OP_CLEAR:    cmd = CMD_CLEAR;
      default:     known = 1'b0;
    endcase
  end

  // Unknown op codes are accepted and dropped here; they never reach the queue.
  assign in_ch.ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready && known;
  assign q_valid     = (cnt_r != '0);
  assign q_item      = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= '{cmd: cmd, coef: in_ch.term_coefficient,
                             expo: in_ch.term_exponent};
    end
  end

endmodule

`default_nettype wire

FILE: design/smpa_back.sv
`default_nettype none

module smpa_back #(
  parameter int MAX_TERMS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  smpa_pkg::cmd_item_t     q_item,
  output logic                    q_pop,
  smpa_out_if.source              out_ch
);
  import smpa_pkg::*;

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);

  logic signed [COEF_W-1:0] a_coef_r [MAX_TERMS];
  logic [EXP_W-1:0]         a_exp_r  [MAX_TERMS];
  logic signed [COEF_W-1:0] b_coef_r [MAX_TERMS];
  logic [EXP_W-1:0]         b_exp_r  [MAX_TERMS];

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_a_r, count_a_nxt;
  logic [CNT_W-1:0]        count_b_r, count_b_nxt;
  logic [CNT_W-1:0]        ia_r, ia_nxt;
  logic [CNT_W-1:0]        ib_r, ib_nxt;
  logic                    sub_r, sub_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [RES_W-1:0] out_coef_r;
  logic [EXP_W-1:0]        out_exp_r;
  logic                    out_last_r;
  status_t                 out_stat_r;

  logic                    slot_free;
  logic                    load;
  logic signed [RES_W-1:0] ld_coef;
  logic [EXP_W-1:0]        ld_exp;
  logic                    ld_last;
  status_t                 ld_stat;
  logic                    wr_a;
  logic                    wr_b;

  logic signed [COEF_W-1:0] head_a_c;
  logic signed [COEF_W-1:0] head_b_c;
  logic [EXP_W-1:0]         head_a_e;
  logic [EXP_W-1:0]         head_b_e;
  logic signed [RES_W-1:0]  ext_a;
  logic signed [RES_W-1:0]  ext_b;
  logic                     a_left;
  logic                     b_left;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign head_a_c  = a_coef_r[ia_r[IDX_W-1:0]];
  assign head_a_e  = a_exp_r[ia_r[IDX_W-1:0]];
  assign head_b_c  = b_coef_r[ib_r[IDX_W-1:0]];
  assign head_b_e  = b_exp_r[ib_r[IDX_W-1:0]];
  assign ext_a     = {head_a_c[COEF_W-1], head_a_c};
  assign ext_b     = {head_b_c[COEF_W-1], head_b_c};
  assign a_left    = (ia_r < count_a_r);
  assign b_left    = (ib_r < count_b_r);

  always_comb begin
    state_nxt   = state_r;
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    ia_nxt      = ia_r;
    ib_nxt      = ib_r;
    sub_nxt     = sub_r;
    q_pop       = 1'b0;
    load        = 1'b0;
    ld_coef     = '0;
    ld_exp      = '0;
    ld_last     = 1'b1;
    ld_stat     = STAT_VALID;
    wr_a        = 1'b0;
    wr_b        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.cmd)
            CMD_APPEND_A: begin
              if (count_a_r == CNT_W'(MAX_TERMS)) begin
                if (slot_free) begin
                  load    = 1'b1;
                  ld_coef = {q_item.coef[COEF_W-1], q_item.coef};
                  ld_exp  = q_item.expo;
                  ld_stat = STAT_DROPPED;
                  q_pop   = 1'b1;
                end
              end else begin
                wr_a        = 1'b1;
                count_a_nxt = count_a_r + CNT_W'(1);
                q_pop       = 1'b1;
              end
            end
            CMD_APPEND_B: begin
              if (count_b_r == CNT_W'(MAX_TERMS)) begin
                if (slot_free) begin
                  load    = 1'b1;
                  ld_coef = {q_item.coef[COEF_W-1], q_item.coef};
                  ld_exp  = q_item.expo;
                  ld_stat = STAT_DROPPED;
                  q_pop   = 1'b1;
                end
              end else begin
                wr_b        = 1'b1;
                count_b_nxt = count_b_r + CNT_W'(1);
                q_pop       = 1'b1;
              end
            end
            CMD_ADD, CMD_SUB: begin
              if (count_a_r == '0 && count_b_r == '0) begin
                if (slot_free) begin
                  load    = 1'b1;
                  ld_stat = STAT_EMPTY;
                  q_pop   = 1'b1;
                end
              end else begin
                ia_nxt    = '0;
                ib_nxt    = '0;
                sub_nxt   = (q_item.cmd == CMD_SUB);
                state_nxt = ST_MERGE;
                q_pop     = 1'b1;
              end
            end
            CMD_CLEAR: begin
              count_a_nxt = '0;
              count_b_nxt = '0;
              q_pop       = 1'b1;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_MERGE: begin
        if (slot_free) begin
          load = 1'b1;
          if (a_left && b_left && head_a_e == head_b_e) begin
            ld_coef = sub_r ? ext_a - ext_b : ext_a + ext_b;
            ld_exp  = head_a_e;
            ia_nxt  = ia_r + CNT_W'(1);
            ib_nxt  = ib_r + CNT_W'(1);
          end else if (!b_left || (a_left && head_a_e > head_b_e)) begin
            ld_coef = ext_a;
            ld_exp  = head_a_e;
            ia_nxt  = ia_r + CNT_W'(1);
          end else begin
            ld_coef = sub_r ? -ext_b : ext_b;
            ld_exp  = head_b_e;
            ib_nxt  = ib_r + CNT_W'(1);
          end
          ld_last = (ia_nxt == count_a_r) && (ib_nxt == count_b_r);
          if (ld_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_a_r   <= '0;
      count_b_r   <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_a_r   <= count_a_nxt;
      count_b_r   <= count_b_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_coef_r <= ld_coef;
      out_exp_r  <= ld_exp;
      out_last_r <= ld_last;
      out_stat_r <= ld_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_coef_r[count_a_r[IDX_W-1:0]] <= q_item.coef;
      a_exp_r[count_a_r[IDX_W-1:0]]  <= q_item.expo;
    end
    if (wr_b) begin
      b_coef_r[count_b_r[IDX_W-1:0]] <= q_item.coef;
      b_exp_r[count_b_r[IDX_W-1:0]]  <= q_item.expo;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.result_coefficient = out_coef_r;
  assign out_ch.result_exponent    = out_exp_r;
  assign out_ch.last_term          = out_last_r;
  assign out_ch.status             = out_stat_r;

endmodule

`default_nettype wire

FILE: design/sparse_polynomial_add_sub_merge_core.sv
// Sparse polynomial add/subtract unit. Terms are appended to list A or B, and an add or
// subtract item merges both lists by exponent, largest first, emitting one result term per
// cycle while the output is not stalled, with the final term marked; appends to a full list
// come back as a dropped result. A two-entry command queue sits in front of the executing
// back end, so the input can take up to two more items while a merge runs or a result waits.
// Appends, clears and an emit on two empty lists are handled in the back end's idle state. A
// merge is dispatched from that state and then emits count_a + count_b minus the number of
// matched exponents result terms from the single merge walk, which reads one head of each
// list per cycle; a stalled output holds the walk.
`default_nettype none

module sparse_polynomial_add_sub_merge_core #(
  parameter int MAX_TERMS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  smpa_in_if.sink    in_ch,
  smpa_out_if.source out_ch
);
  import smpa_pkg::*;

  logic      q_valid;
  logic      q_pop;
  cmd_item_t q_item;

  smpa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  smpa_back #(
    .MAX_TERMS (MAX_TERMS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: verif/sparse_polynomial_add_sub_merge_core_tb.sv
`timescale 1ns / 1ps

module sparse_polynomial_add_sub_merge_core_tb;
  import smpa_pkg::*;

  localparam int MAX_TERMS = 32;
  localparam int TARGET_ITEMS = 180;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [RES_W-1:0] coef;
    logic [EXP_W-1:0]        expo;
    logic                    is_last;
    status_t                 status;
  } poly_term_t;

  class poly_merge_scoreboard;
    logic signed [COEF_W-1:0] a_coef [MAX_TERMS];
    logic [EXP_W-1:0]         a_expo [MAX_TERMS];
    logic signed [COEF_W-1:0] b_coef [MAX_TERMS];
    logic [EXP_W-1:0]         b_expo [MAX_TERMS];
    int                       count_a;
    int                       count_b;
    poly_term_t               pending_terms [$];
    int                       mismatches;

    function new();
      count_a = 0;
      count_b = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void push_term(logic signed [RES_W-1:0] coef, logic [EXP_W-1:0] expo,
                            logic is_last, status_t status);
      poly_term_t t;
      t.coef = coef;
      t.expo = expo;
      t.is_last = is_last;
      t.status = status;
      pending_terms.push_back(t);
    endfunction

    function void merge_lists(bit subtract);
      int ia;
      int ib;
      logic signed [RES_W-1:0] ca;
      logic signed [RES_W-1:0] cb;
      ia = 0;
      ib = 0;
      if (count_a == 0 && count_b == 0) begin
        push_term('0, '0, 1'b1, STAT_EMPTY);
        return;
      end
      while (ia < count_a || ib < count_b) begin
        if (ia < count_a) ca = a_coef[ia];
        if (ib < count_b) cb = b_coef[ib];
        if (ia < count_a && ib < count_b && a_expo[ia] == b_expo[ib]) begin
          push_term(subtract ? ca - cb : ca + cb, a_expo[ia], 1'b0, STAT_VALID);
          ia++;
          ib++;
        end else if (ib >= count_b || (ia < count_a && a_expo[ia] > b_expo[ib])) begin
          push_term(ca, a_expo[ia], 1'b0, STAT_VALID);
          ia++;
        end else begin
          push_term(subtract ? -cb : cb, b_expo[ib], 1'b0, STAT_VALID);
          ib++;
        end
      end
      pending_terms[pending_terms.size() - 1].is_last = 1'b1;
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic signed [COEF_W-1:0] coef,
                            logic [EXP_W-1:0] expo);
      case (op)
        OP_APPEND_A: begin
          if (count_a >= MAX_TERMS) begin
            push_term(coef, expo, 1'b1, STAT_DROPPED);
          end else begin
            a_coef[count_a] = coef;
            a_expo[count_a] = expo;
            count_a++;
          end
        end
        OP_APPEND_B: begin
          if (count_b >= MAX_TERMS) begin
            push_term(coef, expo, 1'b1, STAT_DROPPED);
          end else begin
            b_coef[count_b] = coef;
            b_expo[count_b] = expo;
            count_b++;
          end
        end
        OP_ADD: merge_lists(1'b0);
        OP_SUB: merge_lists(1'b1);
        OP_CLEAR: begin
          count_a = 0;
          count_b = 0;
        end
        default: ;
      endcase
    endfunction

    task check_term(logic signed [RES_W-1:0] coef, logic [EXP_W-1:0] expo,
                    logic is_last, logic [STAT_W-1:0] status);
      poly_term_t t;
      if (pending_terms.size() == 0) begin
        report($sformatf("unexpected term coef %0d expo %0d", coef, expo));
        return;
      end
      t = pending_terms.pop_front();
      if (coef !== t.coef)
        report($sformatf("coefficient got %0d exp %0d", coef, t.coef));
      if (expo !== t.expo)
        report($sformatf("exponent got %0d exp %0d", expo, t.expo));
      if (is_last !== t.is_last)
        report($sformatf("last flag got %0b exp %0b", is_last, t.is_last));
      if (status !== t.status)
        report($sformatf("status code got %0d exp %0d", status, t.status));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   send_idle_en;
  bit   recv_stall_en;
  int   items_sent;

  poly_merge_scoreboard sb;

  smpa_in_if  in_ch ();
  smpa_out_if out_ch ();

  sparse_polynomial_add_sub_merge_core #(
    .MAX_TERMS(MAX_TERMS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= recv_stall_en ? ($urandom_range(99) >= 35) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_term(out_ch.result_coefficient, out_ch.result_exponent,
                    out_ch.last_term, out_ch.status);
    end
  end

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return COEF_W'($urandom());
    endcase
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic signed [COEF_W-1:0] coef,
                           logic [EXP_W-1:0] expo);
    while (send_idle_en && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.term_coefficient <= coef;
    in_ch.term_exponent <= expo;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(op, coef, expo);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_terms.size() != 0) @(posedge clk);
  endtask

  task automatic run_polynomials(int pool_size, bit all_shared, bit force_clear);
    int pool [$];
    int qa [$];
    int qb [$];
    int cur;
    int max_step;
    int member;
    int n_emit;
    if (force_clear || $urandom_range(99) < 80) send_item(OP_CLEAR, rand_coef(), '0);
    cur = ($urandom_range(3) == 0) ? 1023 : $urandom_range(1023, pool_size);
    for (int k = 0; k < pool_size; k++) begin
      pool.push_back(cur);
      max_step = cur - (pool_size - k - 2);
      if (max_step > 40) max_step = 40;
      if (k < pool_size - 1) cur = cur - $urandom_range(max_step, 1);
    end
    if (pool_size > 0 && $urandom_range(3) == 0) pool[pool_size - 1] = 0;
    foreach (pool[k]) begin
      member = all_shared ? 3 : $urandom_range(3, 1);
      if (member != 2) qa.push_back(pool[k]);
      if (member != 1) qb.push_back(pool[k]);
    end
    while (qa.size() != 0 || qb.size() != 0) begin
      if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(1) == 1)) begin
        send_item(OP_APPEND_A, rand_coef(), EXP_W'(qa.pop_front()));
      end else begin
        send_item(OP_APPEND_B, rand_coef(), EXP_W'(qb.pop_front()));
      end
    end
    n_emit = $urandom_range(2, 1);
    repeat (n_emit) send_item($urandom_range(1) ? OP_ADD : OP_SUB, rand_coef(), '0);
  endtask

  initial begin
    int seq_idx;
    int directed_items;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_CLEAR;
    in_ch.term_coefficient = '0;
    in_ch.term_exponent = '0;
    send_idle_en = 1'b1;
    recv_stall_en = 1'b1;
    items_sent = 0;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_ADD, 16'sh0000, '0);
    send_item(OP_SUB, 16'sh0000, '0);
    send_item(OP_SPARE_LO, 16'sh7fff, 10'd1023);
    send_item(OP_SPARE_MID, 16'sh8000, 10'd0);
    send_item(OP_SPARE_HI, 16'sh1234, 10'd345);
    send_item(OP_APPEND_A, 16'sh8000, 10'd1023);
    send_item(OP_APPEND_B, 16'sh8000, 10'd1023);
    send_item(OP_APPEND_A, 16'sh7fff, 10'd700);
    send_item(OP_APPEND_B, 16'sh7fff, 10'd700);
    send_item(OP_APPEND_B, 16'sh8000, 10'd600);
    send_item(OP_APPEND_A, 16'sh0001, 10'd0);
    send_item(OP_APPEND_B, 16'sh0007, 10'd0);
    send_item(OP_ADD, 16'sh0000, '0);
    send_item(OP_SUB, 16'sh0000, '0);
    send_item(OP_APPEND_B, 16'sh0005, 10'd0);
    send_item(OP_SUB, 16'sh0000, '0);
    send_item(OP_CLEAR, 16'sh0000, '0);
    send_item(OP_ADD, 16'sh0000, '0);
    directed_items = items_sent;

    seq_idx = 0;
    while (items_sent < TARGET_ITEMS) begin
      send_idle_en = !(items_sent >= directed_items + 40 && items_sent < directed_items + 90);
      recv_stall_en = send_idle_en;
      if (seq_idx == 2) begin
        run_polynomials(MAX_TERMS + 1, 1'b1, 1'b1);
        wait_drained();
      end else if ($urandom_range(99) < 25) begin
        repeat ($urandom_range(4, 1)) begin
          send_item(OP_W'($urandom_range(7)), COEF_W'($urandom()), EXP_W'($urandom()));
        end
      end else if ($urandom_range(11) == 0) begin
        run_polynomials($urandom_range(40, 20), 1'b0, 1'b0);
      end else begin
        run_polynomials($urandom_range(8), 1'b0, 1'b0);
      end
      seq_idx++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sparse_polynomial_add_sub_merge_core.f
design/smpa_pkg.sv
design/smpa_in_if.sv
design/smpa_out_if.sv
design/smpa_front.sv
design/smpa_back.sv
design/sparse_polynomial_add_sub_merge_core.sv
verif/sparse_polynomial_add_sub_merge_core_tb.sv
